@@ rtl/dsmh_pkg.sv @@
// ----------------------------------------------------------------------------
// dsmh_pkg
// Shared types and constants of the disk stack height block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsmh_pkg;

  localparam int OUT_DIM_W = 16;
  localparam int STACK_W   = 22;

  // controller states
  typedef enum logic [4:0] {
    ST_LOAD, ST_S_START, ST_S_RD, ST_S_KEY, ST_S_CRD, ST_S_CMP, ST_S_PLACE,
    ST_L_START, ST_L_RD, ST_L_KEY, ST_L_JRD, ST_L_JCMP, ST_L_WR,
    ST_T_START, ST_T_RD, ST_T_DAT, ST_E_CH, ST_E_DIM, ST_E_OUT, ST_DONE
  } state_t;

  // datapath commands
  typedef enum logic [4:0] {
    OP_LOAD, OP_S_START, OP_S_RD, OP_S_KEY, OP_S_CRD, OP_S_CMP, OP_S_PLACE,
    OP_L_START, OP_L_RD, OP_L_KEY, OP_L_JRD, OP_L_JCMP, OP_L_WR,
    OP_T_START, OP_T_RD, OP_T_DAT, OP_E_CH, OP_E_DIM, OP_E_OUT, OP_DONE
  } op_t;

  typedef struct packed {
    logic in_last;
    logic i_done;
    logic k_zero;
    logic greater;
    logic j_done;
    logic tr_stop;
    logic len_zero;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/dsmh_if.sv @@
// ----------------------------------------------------------------------------
// dsmh channel interfaces
// Valid/ready channels for incoming disks and for the emitted stack.
// ----------------------------------------------------------------------------
`default_nettype none

interface disk_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] disk_width;
  logic [15:0] disk_depth;
  logic [15:0] disk_height;
  logic        last_disk;

  modport source (output valid, disk_width, disk_depth, disk_height, last_disk,
                  input ready);
  modport sink   (input valid, disk_width, disk_depth, disk_height, last_disk,
                  output ready);
endinterface

interface disk_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_width;
  logic [15:0] out_depth;
  logic [15:0] out_height;
  logic [21:0] stack_height;
  logic        overflow;
  logic        last_result;

  modport source (output valid, out_width, out_depth, out_height, stack_height,
                  overflow, last_result, input ready);
  modport sink   (input valid, out_width, out_depth, out_height, stack_height,
                  overflow, last_result, output ready);
endinterface

`default_nettype wire

@@ rtl/dsmh_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsmh_ctrl
// Sequencer for load, sort, weighted chain search, traceback and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  dsmh_pkg::status_t status,
  output dsmh_pkg::op_t     op
);

  dsmh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsmh_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dsmh_pkg::ST_LOAD:    if (status.in_last) state_next = dsmh_pkg::ST_S_START;
      dsmh_pkg::ST_S_START: state_next = dsmh_pkg::ST_S_RD;
      dsmh_pkg::ST_S_RD: begin
        state_next = status.i_done ? dsmh_pkg::ST_L_START : dsmh_pkg::ST_S_KEY;
      end
      dsmh_pkg::ST_S_KEY:   state_next = dsmh_pkg::ST_S_CRD;
      dsmh_pkg::ST_S_CRD: begin
        state_next = status.k_zero ? dsmh_pkg::ST_S_PLACE : dsmh_pkg::ST_S_CMP;
      end
      dsmh_pkg::ST_S_CMP: begin
        state_next = status.greater ? dsmh_pkg::ST_S_CRD : dsmh_pkg::ST_S_PLACE;
      end
      dsmh_pkg::ST_S_PLACE: state_next = dsmh_pkg::ST_S_RD;
      dsmh_pkg::ST_L_START: state_next = dsmh_pkg::ST_L_RD;
      dsmh_pkg::ST_L_RD: begin
        state_next = status.i_done ? dsmh_pkg::ST_T_START : dsmh_pkg::ST_L_KEY;
      end
      dsmh_pkg::ST_L_KEY:   state_next = dsmh_pkg::ST_L_JRD;
      dsmh_pkg::ST_L_JRD: begin
        state_next = status.j_done ? dsmh_pkg::ST_L_WR : dsmh_pkg::ST_L_JCMP;
      end
      dsmh_pkg::ST_L_JCMP:  state_next = dsmh_pkg::ST_L_JRD;
      dsmh_pkg::ST_L_WR:    state_next = dsmh_pkg::ST_L_RD;
      dsmh_pkg::ST_T_START: state_next = dsmh_pkg::ST_T_RD;
      dsmh_pkg::ST_T_RD:    state_next = dsmh_pkg::ST_T_DAT;
      dsmh_pkg::ST_T_DAT: begin
        state_next = status.tr_stop ? dsmh_pkg::ST_E_CH : dsmh_pkg::ST_T_RD;
      end
      dsmh_pkg::ST_E_CH: begin
        state_next = status.len_zero ? dsmh_pkg::ST_DONE : dsmh_pkg::ST_E_DIM;
      end
      dsmh_pkg::ST_E_DIM:   state_next = dsmh_pkg::ST_E_OUT;
      dsmh_pkg::ST_E_OUT:   if (status.out_free) state_next = dsmh_pkg::ST_E_CH;
      dsmh_pkg::ST_DONE:    state_next = dsmh_pkg::ST_LOAD;
      default:              state_next = dsmh_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    case (state)
      dsmh_pkg::ST_LOAD:    op = dsmh_pkg::OP_LOAD;
      dsmh_pkg::ST_S_START: op = dsmh_pkg::OP_S_START;
      dsmh_pkg::ST_S_RD:    op = dsmh_pkg::OP_S_RD;
      dsmh_pkg::ST_S_KEY:   op = dsmh_pkg::OP_S_KEY;
      dsmh_pkg::ST_S_CRD:   op = dsmh_pkg::OP_S_CRD;
      dsmh_pkg::ST_S_CMP:   op = dsmh_pkg::OP_S_CMP;
      dsmh_pkg::ST_S_PLACE: op = dsmh_pkg::OP_S_PLACE;
      dsmh_pkg::ST_L_START: op = dsmh_pkg::OP_L_START;
      dsmh_pkg::ST_L_RD:    op = dsmh_pkg::OP_L_RD;
      dsmh_pkg::ST_L_KEY:   op = dsmh_pkg::OP_L_KEY;
      dsmh_pkg::ST_L_JRD:   op = dsmh_pkg::OP_L_JRD;
      dsmh_pkg::ST_L_JCMP:  op = dsmh_pkg::OP_L_JCMP;
      dsmh_pkg::ST_L_WR:    op = dsmh_pkg::OP_L_WR;
      dsmh_pkg::ST_T_START: op = dsmh_pkg::OP_T_START;
      dsmh_pkg::ST_T_RD:    op = dsmh_pkg::OP_T_RD;
      dsmh_pkg::ST_T_DAT:   op = dsmh_pkg::OP_T_DAT;
      dsmh_pkg::ST_E_CH:    op = dsmh_pkg::OP_E_CH;
      dsmh_pkg::ST_E_DIM:   op = dsmh_pkg::OP_E_DIM;
      dsmh_pkg::ST_E_OUT:   op = dsmh_pkg::OP_E_OUT;
      dsmh_pkg::ST_DONE:    op = dsmh_pkg::OP_DONE;
      default:              op = dsmh_pkg::OP_LOAD;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/dsmh_dp.sv @@
// ----------------------------------------------------------------------------
// dsmh_dp
// Disk, chain-total and traceback memories with counters and comparators.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmh_dp #(
  parameter int MAX_DISKS = 64,
  parameter int DIM_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  dsmh_pkg::op_t     op,
  output dsmh_pkg::status_t status,
  disk_in_if.sink           in_ch,
  disk_out_if.source        out_ch
);

  localparam int IDX_BITS = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int CNT_BITS = $clog2(MAX_DISKS + 1);
  localparam int TOT_BITS = DIM_BITS + CNT_BITS;
  localparam int EW = (DIM_BITS > dsmh_pkg::OUT_DIM_W) ? DIM_BITS : dsmh_pkg::OUT_DIM_W;
  localparam int SW = (TOT_BITS > dsmh_pkg::STACK_W) ? TOT_BITS : dsmh_pkg::STACK_W;

  typedef struct packed {
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] d;
    logic [DIM_BITS-1:0] h;
  } dims_t;

  typedef struct packed {
    logic [TOT_BITS-1:0] best;
    logic                has_par;
    logic [IDX_BITS-1:0] par;
  } bp_t;

  dims_t               dims_mem [MAX_DISKS];
  bp_t                 bp_mem   [MAX_DISKS];
  logic [IDX_BITS-1:0] ch_mem   [MAX_DISKS];

  dims_t               dims_rd, dims_wd, key;
  bp_t                 bp_rd, bp_wd;
  logic [IDX_BITS-1:0] ch_rd, ch_wd;
  logic                dims_we, dims_re, bp_we, bp_re, ch_we, ch_re;
  logic [IDX_BITS-1:0] dims_wa, dims_ra, bp_wa, bp_ra, ch_wa, ch_ra;

  logic [CNT_BITS-1:0] count, i, j, k, len;
  logic [CNT_BITS-1:0] k_m1, len_m1;
  logic                ovf;
  logic [IDX_BITS-1:0] top, cur_par;
  logic [TOT_BITS-1:0] top_best, cur_best, sum;
  logic                cur_has;

  logic                in_fire, out_free, greater, hit, load_out;
  logic                out_valid;
  logic [EW-1:0]       ow, od, oh;
  logic [SW-1:0]       osh;

  assign in_ch.ready = (op == dsmh_pkg::OP_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign load_out    = (op == dsmh_pkg::OP_E_OUT) && out_free;

  assign k_m1   = k - CNT_BITS'(1);
  assign len_m1 = len - CNT_BITS'(1);
  assign sum    = bp_rd.best + TOT_BITS'(key.h);

  // ordering by width then depth
  assign greater = (dims_rd.w > key.w) || ((dims_rd.w == key.w) && (dims_rd.d > key.d));
  assign hit = (dims_rd.w < key.w) && (dims_rd.d < key.d) && (dims_rd.h < key.h) &&
               (sum > cur_best);

  assign status.in_last  = in_fire && in_ch.last_disk;
  assign status.i_done   = (i >= count);
  assign status.k_zero   = (k == '0);
  assign status.greater  = greater;
  assign status.j_done   = (j == i);
  assign status.tr_stop  = !bp_rd.has_par || (len == count);
  assign status.len_zero = (len == '0);
  assign status.out_free = out_free;

  always_comb begin
    dims_we = 1'b0;
    dims_wa = k[IDX_BITS-1:0];
    dims_wd = key;
    dims_re = 1'b0;
    dims_ra = i[IDX_BITS-1:0];
    bp_we   = 1'b0;
    bp_wa   = i[IDX_BITS-1:0];
    bp_wd   = '{best: cur_best, has_par: cur_has, par: cur_par};
    bp_re   = 1'b0;
    bp_ra   = j[IDX_BITS-1:0];
    ch_we   = 1'b0;
    ch_wa   = len[IDX_BITS-1:0];
    ch_wd   = k[IDX_BITS-1:0];
    ch_re   = 1'b0;
    ch_ra   = len_m1[IDX_BITS-1:0];
    case (op)
      dsmh_pkg::OP_LOAD: begin
        dims_we = in_fire && (count < CNT_BITS'(MAX_DISKS));
        dims_wa = count[IDX_BITS-1:0];
        dims_wd = '{w: DIM_BITS'(in_ch.disk_width), d: DIM_BITS'(in_ch.disk_depth),
                    h: DIM_BITS'(in_ch.disk_height)};
      end
      dsmh_pkg::OP_S_RD: dims_re = !status.i_done;
      dsmh_pkg::OP_S_CRD: begin
        dims_re = !status.k_zero;
        dims_ra = k_m1[IDX_BITS-1:0];
      end
      dsmh_pkg::OP_S_CMP: begin
        dims_we = greater;
        dims_wd = dims_rd;
      end
      dsmh_pkg::OP_S_PLACE: dims_we = 1'b1;
      dsmh_pkg::OP_L_RD:    dims_re = !status.i_done;
      dsmh_pkg::OP_L_JRD: begin
        dims_re = !status.j_done;
        dims_ra = j[IDX_BITS-1:0];
        bp_re   = !status.j_done;
      end
      dsmh_pkg::OP_L_WR: bp_we = 1'b1;
      dsmh_pkg::OP_T_RD: begin
        bp_re = 1'b1;
        bp_ra = k[IDX_BITS-1:0];
        ch_we = 1'b1;
      end
      dsmh_pkg::OP_E_CH: ch_re = !status.len_zero;
      dsmh_pkg::OP_E_DIM: begin
        dims_re = 1'b1;
        dims_ra = ch_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (dims_we) dims_mem[dims_wa] <= dims_wd;
    if (dims_re) dims_rd <= dims_mem[dims_ra];
    if (bp_we) bp_mem[bp_wa] <= bp_wd;
    if (bp_re) bp_rd <= bp_mem[bp_ra];
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    if (ch_re) ch_rd <= ch_mem[ch_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      len   <= '0;
    end else begin
      case (op)
        dsmh_pkg::OP_LOAD: begin
          if (in_fire) begin
            if (count < CNT_BITS'(MAX_DISKS)) count <= count + CNT_BITS'(1);
            else ovf <= 1'b1;
          end
        end
        dsmh_pkg::OP_S_START: i <= CNT_BITS'(1);
        dsmh_pkg::OP_S_KEY:   k <= i;
        dsmh_pkg::OP_S_CMP:   if (greater) k <= k_m1;
        dsmh_pkg::OP_S_PLACE: i <= i + CNT_BITS'(1);
        dsmh_pkg::OP_L_START: i <= '0;
        dsmh_pkg::OP_L_KEY:   j <= '0;
        dsmh_pkg::OP_L_JCMP:  j <= j + CNT_BITS'(1);
        dsmh_pkg::OP_L_WR:    i <= i + CNT_BITS'(1);
        dsmh_pkg::OP_T_START: begin
          k   <= CNT_BITS'(top);
          len <= '0;
        end
        dsmh_pkg::OP_T_RD:    len <= len + CNT_BITS'(1);
        dsmh_pkg::OP_T_DAT:   if (!status.tr_stop) k <= CNT_BITS'(bp_rd.par);
        dsmh_pkg::OP_E_OUT:   if (out_free) len <= len_m1;
        dsmh_pkg::OP_DONE: begin
          count <= '0;
          ovf   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // working values of the disk under test
  always_ff @(posedge clk) begin
    case (op)
      dsmh_pkg::OP_S_KEY: key <= dims_rd;
      dsmh_pkg::OP_L_KEY: begin
        key      <= dims_rd;
        cur_best <= TOT_BITS'(dims_rd.h);
        cur_has  <= 1'b0;
      end
      dsmh_pkg::OP_L_JCMP: begin
        if (hit) begin
          cur_best <= sum;
          cur_has  <= 1'b1;
          cur_par  <= j[IDX_BITS-1:0];
        end
      end
      dsmh_pkg::OP_L_WR: begin
        // first maximum wins
        if ((i == '0) || (cur_best > top_best)) begin
          top      <= i[IDX_BITS-1:0];
          top_best <= cur_best;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ow                 <= EW'(dims_rd.w);
      od                 <= EW'(dims_rd.d);
      oh                 <= EW'(dims_rd.h);
      osh                <= SW'(top_best);
      out_ch.overflow    <= ovf;
      out_ch.last_result <= (len == CNT_BITS'(1));
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_width    = ow[dsmh_pkg::OUT_DIM_W-1:0];
  assign out_ch.out_depth    = od[dsmh_pkg::OUT_DIM_W-1:0];
  assign out_ch.out_height   = oh[dsmh_pkg::OUT_DIM_W-1:0];
  assign out_ch.stack_height = osh[dsmh_pkg::STACK_W-1:0];

`ifndef SYNTHESIS
  a_j_below_i: assert property (@(posedge clk) disable iff (rst)
    (op == dsmh_pkg::OP_L_JCMP) |-> (j < i))
    else $error("chain search compares a disk that is not earlier");
  a_place_in_range: assert property (@(posedge clk) disable iff (rst)
    (op == dsmh_pkg::OP_S_PLACE) |-> (k <= i))
    else $error("insertion point beyond the disk being sorted");
  a_chain_bounded: assert property (@(posedge clk) disable iff (rst)
    (op == dsmh_pkg::OP_T_RD) |-> (len < count))
    else $error("traceback longer than the stored set");
`endif

endmodule

`default_nettype wire

@@ rtl/disk_stack_max_height.sv @@
// ----------------------------------------------------------------------------
// disk_stack_max_height
// Tallest stack of disks, strictly smaller in all three dimensions.
// ----------------------------------------------------------------------------
// channel   direction  payload
// in_ch     sink       disk_width, disk_depth, disk_height, last_disk
// out_ch    source     out_width, out_depth, out_height, stack_height,
//                      overflow, last_result
//
// loading takes one cycle per disk; the transaction marked last closes the set
// and starts an insertion sort; the chain search compares each disk with every
// earlier one, traceback follows parent links, emission sends one result per
// stack disk; all through one read port on the disk memory
// reset is synchronous; memories are not cleared, only counters and flags
// a stalled result holds the emission sequencer; no disk is taken until the
// whole stack has been handed to the output register
// ----------------------------------------------------------------------------
`default_nettype none

module disk_stack_max_height #(
  parameter int MAX_DISKS = 64,
  parameter int DIM_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  disk_in_if.sink    in_ch,
  disk_out_if.source out_ch
);

  dsmh_pkg::op_t     op;
  dsmh_pkg::status_t status;

  dsmh_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .op     (op)
  );

  dsmh_dp #(
    .MAX_DISKS (MAX_DISKS),
    .DIM_BITS  (DIM_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .status (status),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
